// ----- hdl/tpm_pkg.sv -----
// Package for the trace polynomial mod p block.
// Holds field widths, register indexes, the front-to-back request type
// and the modular add and subtract helpers. Depends on nothing.
`default_nettype none
package tpm_pkg;

  localparam int ModW    = 63;
  localparam int DataW   = 64;
  localparam int WeightW = 11;

  // Configuration register indexes.
  localparam logic [0:0] CFG_MODULUS = 1'b0;
  localparam logic [0:0] CFG_WEIGHT  = 1'b1;

  // One reduced request passed from the front to the back.
  typedef struct packed {
    logic            zero_mod;
    logic [ModW-1:0] t;
    logic [ModW-1:0] n;
  } tpm_job_t;

  // a + b mod m, with a, b < m.
  function automatic logic [ModW-1:0] add_mod(input logic [ModW-1:0] a,
                                              input logic [ModW-1:0] b,
                                              input logic [ModW-1:0] m);
    logic [ModW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[ModW-1:0];
  endfunction

  // a - b mod m, with a, b < m.
  function automatic logic [ModW-1:0] sub_mod(input logic [ModW-1:0] a,
                                              input logic [ModW-1:0] b,
                                              input logic [ModW-1:0] m);
    logic [ModW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + {1'b0, m};
    end
    return d[ModW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tpm_if.sv -----
// Valid/ready channel interfaces for the trace polynomial mod p block.
// Uses the field widths from tpm_pkg.
`default_nettype none
interface tpm_in_if;
  import tpm_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] trace_value;
  logic [DataW-1:0] norm_value;
  modport source (output valid, output trace_value, output norm_value, input ready);
  modport sink (input valid, input trace_value, input norm_value, output ready);
endinterface

interface tpm_out_if;
  import tpm_pkg::*;
  logic            valid;
  logic            ready;
  logic [ModW-1:0] residue;
  modport source (output valid, output residue, input ready);
  modport sink (input valid, input residue, output ready);
endinterface
`default_nettype wire

// ----- hdl/tpm_front.sv -----
// Front end: accepts a request and reduces t and n into 0..p-1 with a
// bit-serial restoring remainder unit. Depends on tpm_pkg and tpm_in_if.
`default_nettype none
module tpm_front import tpm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  tpm_in_if.sink               item_i,
  input  wire logic [ModW-1:0] modulus_i,
  output tpm_job_t             job_o,
  output logic                 job_valid_o,
  input  wire logic            job_ready_i
);

  typedef enum logic [1:0] {IDLE, RED_T, RED_N, PUSH} state_e;

  state_e           state_q;
  logic [DataW-1:0] raw_n_q, mag_q, rem_q;
  logic             neg_q, zero_q;
  logic [5:0]       cnt_q;
  logic [ModW-1:0]  t_q, n_q;
  logic [DataW-1:0] rem_shift, rem_next, fin;

  function automatic logic [DataW-1:0] magnitude(input logic [DataW-1:0] x);
    return x[DataW-1] ? (~x + 64'd1) : x;
  endfunction

  // One remainder bit per cycle; fold negative values up at the end.
  always_comb begin
    rem_shift = {rem_q[DataW-2:0], mag_q[DataW-1]};
    rem_next  = (rem_shift >= {1'b0, modulus_i}) ? rem_shift - {1'b0, modulus_i}
                                                 : rem_shift;
    fin       = (neg_q && rem_next != '0) ? {1'b0, modulus_i} - rem_next : rem_next;
  end

  assign item_i.ready = (state_q == IDLE);
  assign job_valid_o  = (state_q == PUSH);
  assign job_o        = '{zero_mod: zero_q, t: t_q, n: n_q};

  // Sequencer for the two reductions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      zero_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (item_i.valid) begin
            raw_n_q <= item_i.norm_value;
            mag_q   <= magnitude(item_i.trace_value);
            neg_q   <= item_i.trace_value[DataW-1];
            rem_q   <= '0;
            cnt_q   <= '0;
            t_q     <= '0;
            n_q     <= '0;
            if (modulus_i < 63'd2) begin
              zero_q  <= 1'b1;
              state_q <= PUSH;
            end else begin
              zero_q  <= 1'b0;
              state_q <= RED_T;
            end
          end
        end
        RED_T, RED_N: begin
          mag_q <= mag_q << 1;
          rem_q <= rem_next;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(DataW - 1)) begin
            if (state_q == RED_T) begin
              t_q     <= fin[ModW-1:0];
              mag_q   <= magnitude(raw_n_q);
              neg_q   <= raw_n_q[DataW-1];
              rem_q   <= '0;
              cnt_q   <= '0;
              state_q <= RED_N;
            end else begin
              n_q     <= fin[ModW-1:0];
              state_q <= PUSH;
            end
          end
        end
        PUSH: begin
          if (job_ready_i) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tpm_queue.sv -----
// Small register queue between the front and the back.
// Depends on tpm_pkg for the request type.
`default_nettype none
module tpm_queue import tpm_pkg::*; #(
  parameter int Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  tpm_job_t  push_data_i,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  output tpm_job_t  pop_data_o,
  output logic      pop_valid_o,
  input  wire logic pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tpm_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= bump(wr_q);
      if (do_pop)  rd_q <= bump(rd_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ----- hdl/tpm_mulmod.sv -----
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// Depends on tpm_pkg for add_mod.
`default_nettype none
module tpm_mulmod import tpm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [ModW-1:0] a_i,
  input  wire logic [ModW-1:0] b_i,
  input  wire logic [ModW-1:0] m_i,
  output logic                 done_o,
  output logic [ModW-1:0]      result_o
);

  logic            busy_q;
  logic [ModW-1:0] acc_q, addend_q, mult_q;

  assign done_o   = busy_q && (mult_q == '0);
  assign result_o = acc_q;

  // Accumulate doubled addends for each set multiplier bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      acc_q    <= '0;
      addend_q <= a_i;
      mult_q   <= b_i;
    end else if (busy_q) begin
      if (mult_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        if (mult_q[0]) acc_q <= add_mod(acc_q, addend_q, m_i);
        addend_q <= add_mod(addend_q, addend_q, m_i);
        mult_q   <= mult_q >> 1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tpm_back.sv -----
// Back end: runs the recurrence P_i = t*P_{i-1} - n*P_{i-2} mod p on the
// shared multiplier and holds the result register. Depends on tpm_pkg,
// tpm_mulmod and tpm_out_if.
`default_nettype none
module tpm_back import tpm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [ModW-1:0]    modulus_i,
  input  wire logic [WeightW-1:0] degree_i,
  input  tpm_job_t                job_i,
  input  wire logic               job_valid_i,
  output logic                    pop_o,
  tpm_out_if.source               result_o
);

  typedef enum logic [2:0] {IDLE, MUL_TC, WAIT_TC, MUL_NP, WAIT_NP, EMIT} state_e;

  state_e             state_q;
  logic [ModW-1:0]    t_q, n_q, prev_q, cur_q, x_q, res_q, out_q;
  logic [WeightW-1:0] steps_q;
  logic               out_valid_q;
  logic               mul_start, mul_done, emit_fire;
  logic [ModW-1:0]    mul_a, mul_b, mul_res, next_val;

  assign pop_o           = (state_q == IDLE) && job_valid_i;
  assign mul_start       = (state_q == MUL_TC) || (state_q == MUL_NP);
  assign mul_a           = (state_q == MUL_TC) ? t_q : n_q;
  assign mul_b           = (state_q == MUL_TC) ? cur_q : prev_q;
  assign next_val        = sub_mod(x_q, mul_res, modulus_i);
  assign emit_fire       = (state_q == EMIT) && (!out_valid_q || result_o.ready);
  assign result_o.valid   = out_valid_q;
  assign result_o.residue = out_q;

  tpm_mulmod u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .m_i      (modulus_i),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  // Recurrence sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
      steps_q     <= '0;
    end else begin
      if (emit_fire) out_valid_q <= 1'b1;
      else if (out_valid_q && result_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        IDLE: begin
          if (job_valid_i) begin
            t_q    <= job_i.t;
            n_q    <= job_i.n;
            prev_q <= 63'd1;
            cur_q  <= job_i.t;
            if (job_i.zero_mod) begin
              res_q   <= '0;
              state_q <= EMIT;
            end else if (degree_i == '0) begin
              res_q   <= 63'd1;
              state_q <= EMIT;
            end else if (degree_i == 11'd1) begin
              res_q   <= job_i.t;
              state_q <= EMIT;
            end else begin
              steps_q <= degree_i - 11'd1;
              state_q <= MUL_TC;
            end
          end
        end
        MUL_TC: state_q <= WAIT_TC;
        WAIT_TC: begin
          if (mul_done) begin
            x_q     <= mul_res;
            state_q <= MUL_NP;
          end
        end
        MUL_NP: state_q <= WAIT_NP;
        WAIT_NP: begin
          if (mul_done) begin
            prev_q  <= cur_q;
            cur_q   <= next_val;
            steps_q <= steps_q - 11'd1;
            if (steps_q == 11'd1) begin
              res_q   <= next_val;
              state_q <= EMIT;
            end else begin
              state_q <= MUL_TC;
            end
          end
        end
        EMIT: begin
          if (emit_fire) begin
            out_q   <= res_q;
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/trace_polynomial_mod_p.sv -----
// Trace polynomial mod p. The front reduces t and n with two bit-serial
// remainders; the back runs the recurrence with two modular multiplies per
// step, each one multiplier bit at a time, and these multiplies set the rate.
// Throughput is one item per back-end run; the front reduces the next item
// meanwhile. Reset is asynchronous, active low: modulus and weight return to 2.
`default_nettype none
module trace_polynomial_mod_p import tpm_pkg::*; #(
  parameter int MAX_WEIGHT = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  tpm_in_if.sink               item_i,
  tpm_out_if.source            result_o,
  input  wire logic            cfg_we_i,
  input  wire logic [0:0]      cfg_idx_i,
  input  wire logic [ModW-1:0] cfg_data_i
);

  localparam logic [WeightW-1:0] MaxDeg =
    (MAX_WEIGHT > 2047) ? 11'd2045 : WeightW'(MAX_WEIGHT - 2);

  logic [ModW-1:0]    modulus_q;
  logic [WeightW-1:0] weight_q, degree;
  tpm_job_t           fq_data, bq_data;
  logic               fq_valid, fq_ready, bq_valid, bq_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= 63'd2;
      weight_q  <= 11'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS: modulus_q <= cfg_data_i;
        CFG_WEIGHT:  weight_q  <= cfg_data_i[WeightW-1:0];
        default: ;
      endcase
    end
  end

  // Degree from the clamped weight.
  always_comb begin
    if (weight_q < 11'd2) degree = '0;
    else if (weight_q - 11'd2 > MaxDeg) degree = MaxDeg;
    else degree = weight_q - 11'd2;
  end

  tpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .modulus_i   (modulus_q),
    .job_o       (fq_data),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready)
  );

  tpm_queue #(.Depth(2)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (fq_data),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .pop_data_o   (bq_data),
    .pop_valid_o  (bq_valid),
    .pop_i        (bq_pop)
  );

  tpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .modulus_i   (modulus_q),
    .degree_i    (degree),
    .job_i       (bq_data),
    .job_valid_i (bq_valid),
    .pop_o       (bq_pop),
    .result_o    (result_o)
  );

  // With a modulus of two or more, a delivered residue lies below the modulus.
  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && modulus_q >= 63'd2) |-> (result_o.residue < modulus_q))
    else $error("residue not below modulus");

  // A modulus below two gives a zero residue.
  a_res_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && modulus_q < 63'd2) |-> (result_o.residue == '0))
    else $error("nonzero residue for modulus below two");

  // The front goes busy right after it takes a request.
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("front still ready after accepting a request");

endmodule
`default_nettype wire

// ----- tb/tpm_checker.sv -----
// Checker for the trace polynomial mod p block: watches both channels and the
// register write port, predicts each residue and compares it on arrival.
// Depends on tpm_pkg and the channel interfaces in tpm_if.
`timescale 1ns / 100ps
module tpm_checker import tpm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  tpm_in_if                    item_i,
  tpm_out_if                   result_i,
  input  wire logic            cfg_we_i,
  input  wire logic [0:0]      cfg_idx_i,
  input  wire logic [ModW-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [ModW-1:0]    modulus_q;
  logic [WeightW-1:0] weight_q;
  logic [ModW-1:0]    residue_queue[$];

  // Exact modular product through a wide intermediate.
  function automatic logic [ModW-1:0] mul_mod_p(input logic [ModW-1:0] a,
                                                input logic [ModW-1:0] b,
                                                input logic [ModW-1:0] m);
    logic [127:0] prod;
    prod = {65'd0, a} * {65'd0, b};
    prod = prod % {65'd0, m};
    return prod[ModW-1:0];
  endfunction

  // Two's complement value into 0..m-1, negatives wrapped upward.
  function automatic logic [ModW-1:0] wrap_signed(input logic [DataW-1:0] x,
                                                  input logic [ModW-1:0] m);
    logic [DataW-1:0] mag;
    logic [DataW-1:0] r;
    if (x[DataW-1]) begin
      mag = -x;
      r = mag % {1'b0, m};
      return (r == '0) ? '0 : m - r[ModW-1:0];
    end
    r = x % {1'b0, m};
    return r[ModW-1:0];
  endfunction

  // Runs the recurrence P_i = t*P_{i-1} - n*P_{i-2} up to degree weight-2.
  function automatic logic [ModW-1:0] trace_poly(input logic [DataW-1:0] tv,
                                                 input logic [DataW-1:0] nv,
                                                 input logic [ModW-1:0] m,
                                                 input logic [WeightW-1:0] w);
    int              deg;
    logic [ModW-1:0] t;
    logic [ModW-1:0] n;
    logic [ModW-1:0] prev;
    logic [ModW-1:0] cur;
    logic [ModW-1:0] nxt;
    if (m < ModW'(2)) return '0;
    deg = (w < WeightW'(2)) ? 0 : ((w > WeightW'(1024)) ? 1022 : int'(w) - 2);
    t = wrap_signed(tv, m);
    n = wrap_signed(nv, m);
    if (deg == 0) return ModW'(1);
    prev = ModW'(1);
    cur = t;
    for (int i = 2; i <= deg; i++) begin
      nxt = sub_mod(mul_mod_p(t, cur, m), mul_mod_p(n, prev, m), m);
      prev = cur;
      cur = nxt;
    end
    return cur;
  endfunction

  // Shadow registers follow the write port.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModW'(2);
      weight_q <= WeightW'(2);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MODULUS) modulus_q <= cfg_data_i;
      else if (cfg_idx_i == CFG_WEIGHT) weight_q <= cfg_data_i[WeightW-1:0];
    end
  end

  // Predict on every accepted request, compare on every accepted result.
  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    logic [ModW-1:0] want;
    if (rst_ni && item_i.valid && item_i.ready) begin
      residue_queue.push_back(trace_poly(item_i.trace_value, item_i.norm_value,
                                         modulus_q, weight_q));
    end
    if (rst_ni && result_i.valid && result_i.ready) begin
      if (residue_queue.size() == 0) begin
        $error("residue %0d arrived with nothing expected", result_i.residue);
        fail_count_o++;
      end else begin
        want = residue_queue.pop_front();
        if (result_i.residue !== want) begin
          $error("residue: expected %0d, actual %0d", want, result_i.residue);
          fail_count_o++;
        end
      end
    end
    pending_o = residue_queue.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top of the trace polynomial mod p testbench: clock, reset, stimulus,
// register writes and the verdict. Depends on tpm_pkg, tpm_if and tpm_checker.
`timescale 1ns / 100ps
module tb;
  import tpm_pkg::*;

  localparam int          StallLimit = 600000;
  localparam logic [62:0] BigPrime   = 63'd9223372036854775783;
  localparam logic [62:0] MaxMod     = 63'h7FFF_FFFF_FFFF_FFFF;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [0:0]      cfg_idx;
  logic [ModW-1:0] cfg_data;
  int              fail_count;
  int              pending;
  int              idle_cycles;
  int              sent;
  bit              steady_sink;

  tpm_in_if  item_ch ();
  tpm_out_if result_ch ();

  trace_polynomial_mod_p dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tpm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_ch),
    .result_i     (result_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: too long without any accepted request or result ends the run.
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, with stretches of none.
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 30) == 0) steady_sink = ~steady_sink;
      gap = steady_sink ? 0 : $urandom_range(0, 18);
      @(negedge clk_i);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
    end
  end

  // Writes one register at the next falling edge.
  task automatic write_reg(input logic [0:0] idx, input logic [ModW-1:0] value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Picks an operand, often near the edges of the field or of the modulus.
  function automatic logic [63:0] pick_operand(input logic [62:0] m);
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return {1'b0, m} - 64'd1;
      5: return -{1'b0, m};
      6: return {1'b0, m};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sends one request; valid is left high after acceptance.
  task automatic send_item(input logic [63:0] tv, input logic [63:0] nv);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.trace_value <= tv;
    item_ch.norm_value <= nv;
    do @(posedge clk_i); while (!item_ch.ready);
    sent++;
  endtask

  // Waits until every expected residue has come, then lets the block settle.
  task automatic drain();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // One setting of both registers followed by a run of requests.
  task automatic run_phase(input logic [62:0] m, input logic [62:0] w, input int count);
    write_reg(CFG_MODULUS, m);
    write_reg(CFG_WEIGHT, w);
    repeat (count) send_item(pick_operand(m), pick_operand(m));
    drain();
  endtask

  // Stimulus and verdict.
  initial begin
    logic [62:0] m;
    logic [62:0] w;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MODULUS;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.trace_value = '0;
    item_ch.norm_value = '0;
    idle_cycles = 0;
    sent = 0;
    steady_sink = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset values, field extremes, small and huge moduli,
    // weights below two and above the maximum.
    send_item(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_item('1, 64'd0);
    drain();
    run_phase(63'd0, 63'd5, 2);
    run_phase(63'd1, 63'd3, 2);
    run_phase(63'd7, 63'd0, 2);
    run_phase(63'd7, 63'd1, 2);
    run_phase(63'd11, 63'd2047, 1);
    run_phase(MaxMod, 63'd6, 4);
    run_phase(BigPrime, 63'd1024, 1);
    run_phase(63'd3, 63'd3, 3);
    run_phase(63'd2, 63'd4, 2);

    // Random phases, mostly low degree.
    while (sent < 1250) begin
      case ($urandom_range(0, 7))
        0: m = 63'd3;
        1: m = 63'd13;
        2: m = 63'd65521;
        3: m = BigPrime;
        4: m = MaxMod;
        5: m = {31'd0, $urandom};
        6: m = {$urandom, $urandom};
        default: m = 63'($urandom_range(2, 1000));
      endcase
      w = ($urandom_range(0, 7) == 0) ? 63'($urandom_range(0, 40))
                                      : 63'($urandom_range(2, 9));
      run_phase(m, w, $urandom_range(20, 80));
    end

    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tpm_pkg.sv
hdl/tpm_if.sv
hdl/tpm_front.sv
hdl/tpm_queue.sv
hdl/tpm_mulmod.sv
hdl/tpm_back.sv
hdl/trace_polynomial_mod_p.sv
tb/tpm_checker.sv
tb/tb.sv
